FILE: rtl/aht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aht_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // Slot state codes
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam int HOME_SHIFT = 12;
  localparam int REQ_W      = 32;
  localparam int BYTES_W    = 33;
  localparam int SLOT_OUT_W = 10;
  localparam int PSHIFT_W   = 5;
  localparam int STEP_BITS  = 16;

  localparam logic [PSHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

endpackage

`default_nettype wire

FILE: rtl/aht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module aht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/aht_home.sv
`timescale 1ns / 1ps
`default_nettype none

module aht_home
  import aht_pkg::*;
#(
  parameter int SLOTS = 1024,
  parameter int KEY_W = 36,
  localparam int SLOT_W = $clog2(SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   done,
  output logic      [SLOT_W-1:0] home
);

  if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
    // Power-of-two slot count: the remainder is the low bits
    logic [KEY_W+SLOT_W-1:0] key_ext;

    assign key_ext = (KEY_W + SLOT_W)'(key);

    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        home <= key_ext[SLOT_W-1:0];
      end
    end
  end else begin : g_recip
    // Reduce STEP_BITS key bits per step, MSB first: v = rem * 2^STEP_BITS + chunk.
    // A registered reciprocal-multiply quotient estimate is low by at most one,
    // so one compare and subtract then finishes the remainder.
    localparam int QP    = ((KEY_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS = QP / STEP_BITS;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int VW    = SLOT_W + STEP_BITS;
    localparam int MW    = STEP_BITS + 1;
    localparam int PW    = VW + MW;
    localparam logic [MW-1:0] RECIP    = MW'((64'd1 << VW) / 64'(SLOTS));
    localparam logic [VW-1:0] MODV     = VW'(SLOTS);
    localparam logic [CW-1:0] LAST_CNT = CW'(STEPS - 1);

    logic [QP-1:0]        sh;
    logic [SLOT_W-1:0]    rem;
    logic [SLOT_W-1:0]    rem_next;
    logic [VW-1:0]        v;
    logic [PW-1:0]        prod;
    logic [STEP_BITS-1:0] quo;
    logic [VW-1:0]        part;
    logic [VW-1:0]        diff;
    logic [CW-1:0]        cnt;
    logic                 phase;
    logic                 run;

    assign v        = {rem, sh[QP-1 -: STEP_BITS]};
    assign prod     = PW'(v) * PW'(RECIP);
    assign part     = VW'(quo) * MODV;
    assign diff     = v - part;
    assign rem_next = (diff >= MODV) ? SLOT_W'(diff - MODV) : SLOT_W'(diff);

    always_ff @(posedge clk) begin
      if (rst) begin
        run  <= 1'b0;
        done <= 1'b0;
      end else begin
        done <= 1'b0;
        if (start) begin
          run <= 1'b1;
        end else if (run && phase && cnt == LAST_CNT) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
      if (start) begin
        sh    <= QP'(key);
        rem   <= '0;
        cnt   <= '0;
        phase <= 1'b0;
      end else if (run) begin
        phase <= !phase;
        if (!phase) begin
          quo <= prod[VW +: STEP_BITS];
        end else begin
          sh  <= sh << STEP_BITS;
          rem <= rem_next;
          cnt <= cnt + CW'(1);
        end
      end
    end

    assign home = rem;
  end

endmodule

`default_nettype wire

FILE: rtl/allocation_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         start / busy           operation, address, request_bytes
// result    out        done (one-cycle pulse) status, region_bytes, slot
// config    in         cfg_we                 cfg_wdata (page_shift)
//
// An item is taken when start is high and busy is low. The result strobe done
// rises after the home-slot reduction unit has finished and the slots have been
// probed. A refused insert (table half full) answers once the home-slot
// reduction finishes, without probing. The probe loop reads one slot a cycle
// from the slot memories; busy falls as the result shows, so the block takes a
// new item only once the last one's result shows. After reset, busy stays high
// while a clearing pass marks every slot empty. The receiver cannot stall; each
// result is valid for exactly the cycle done is high.

module allocation_hash_table_core
  import aht_pkg::*;
#(
  parameter int TABLE_SLOTS  = 1024,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    operation,
  input  wire logic [ADDRESS_BITS-1:0] address,
  input  wire logic [REQ_W-1:0]        request_bytes,
  input  wire logic                    cfg_we,
  input  wire logic [PSHIFT_W-1:0]     cfg_wdata,
  output logic                         done,
  output logic      [1:0]              status,
  output logic      [BYTES_W-1:0]      region_bytes,
  output logic      [SLOT_OUT_W-1:0]   slot
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int LC_W   = $clog2(TABLE_SLOTS / 2 + 1);
  localparam int KEY_W  = ADDRESS_BITS - HOME_SHIFT;
  localparam int DATA_W = ADDRESS_BITS + BYTES_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_VISIT = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [LC_W-1:0]   HALF_FULL  = LC_W'(TABLE_SLOTS / 2);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_PROBE = 4'b1000
  } fsm_t;

  fsm_t fsm;

  logic [PSHIFT_W-1:0]     page_shift;
  logic [LC_W-1:0]         live_count;
  logic [SLOT_W-1:0]       clr_slot;
  logic                    op_reg;
  logic [ADDRESS_BITS-1:0] addr_reg;
  logic [BYTES_W-1:0]      bytes_reg;
  logic [SLOT_W-1:0]       rd_slot;
  logic [SLOT_W-1:0]       eval_slot;
  logic                    data_valid;
  logic [CNT_W-1:0]        visits;

  logic                    accept;
  logic [BYTES_W-1:0]      page_mask;
  logic [BYTES_W-1:0]      rounded;
  logic                    home_start;
  logic                    home_done;
  logic [SLOT_W-1:0]       home;

  // Slot memories: state is cleared after reset, key/size only when written
  logic                    st_we;
  logic [SLOT_W-1:0]       st_waddr;
  logic [1:0]              st_wdata;
  logic [1:0]              st_rdata;
  logic                    dt_we;
  logic [DATA_W-1:0]       dt_wdata;
  logic [DATA_W-1:0]       dt_rdata;

  logic [ADDRESS_BITS-1:0] rd_addr;
  logic [BYTES_W-1:0]      rd_bytes;
  logic                    eval;
  logic                    ins_hit;
  logic                    rem_hit;
  logic                    rem_miss;
  logic                    lap_end;
  logic [SLOT_W-1:0]       rd_slot_next;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  assign busy   = (fsm != S_IDLE);
  assign accept = start && !busy;

  // Round the request up to a whole page; 33 bits hold the carry
  assign page_mask = (BYTES_W'(1) << page_shift) - BYTES_W'(1);
  assign rounded   = (BYTES_W'(request_bytes) + page_mask) & ~page_mask;

  assign home_start = accept;

  aht_home #(
    .SLOTS (TABLE_SLOTS),
    .KEY_W (KEY_W)
  ) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (home_start),
    .key   (address[ADDRESS_BITS-1:HOME_SHIFT]),
    .done  (home_done),
    .home  (home)
  );

  aht_ram #(
    .WIDTH (2),
    .DEPTH (TABLE_SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_slot),
    .rdata (st_rdata)
  );

  aht_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (dt_we),
    .waddr (eval_slot),
    .wdata (dt_wdata),
    .raddr (rd_slot),
    .rdata (dt_rdata)
  );

  // Read data belongs to eval_slot, the registered copy of rd_slot
  assign rd_addr  = dt_rdata[DATA_W-1:BYTES_W];
  assign rd_bytes = dt_rdata[BYTES_W-1:0];
  assign eval     = (fsm == S_PROBE) && data_valid;
  assign ins_hit  = (op_reg == OP_INSERT) && (st_rdata != SLOT_LIVE);
  assign rem_hit  = (op_reg == OP_REMOVE) && (st_rdata == SLOT_LIVE) && (rd_addr == addr_reg);
  assign rem_miss = (op_reg == OP_REMOVE) && (st_rdata == SLOT_EMPTY);
  assign lap_end  = (visits == LAST_VISIT);

  assign rd_slot_next = (rd_slot == LAST_SLOT) ? '0 : rd_slot + SLOT_W'(1);
  assign slot_ext     = {{SLOT_OUT_W{1'b0}}, eval_slot};

  // Write back only in the clearing pass or at the end of a probe, so the
  // speculative reads ahead never see a stale entry
  always_comb begin
    st_we    = 1'b0;
    st_waddr = eval_slot;
    st_wdata = SLOT_LIVE;
    dt_we    = 1'b0;
    dt_wdata = {addr_reg, bytes_reg};
    if (fsm == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_slot;
      st_wdata = SLOT_EMPTY;
    end else if (eval && ins_hit) begin
      st_we = 1'b1;
      dt_we = 1'b1;
    end else if (eval && rem_hit) begin
      st_we    = 1'b1;
      st_wdata = SLOT_TOMB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= S_CLEAR;
      clr_slot   <= '0;
      page_shift <= PAGE_SHIFT_RESET;
      live_count <= '0;
      done       <= 1'b0;
      data_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_shift <= cfg_wdata;
      end
      done <= 1'b0;
      unique case (fsm)
        S_CLEAR: begin
          // Sweep every slot to empty, one per cycle
          clr_slot <= clr_slot + SLOT_W'(1);
          if (clr_slot == LAST_SLOT) begin
            fsm <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_reg    <= operation;
            addr_reg  <= address;
            bytes_reg <= rounded;
            fsm       <= S_HASH;
          end
        end
        S_HASH: begin
          if (home_done) begin
            if (op_reg == OP_INSERT && live_count >= HALF_FULL) begin
              // Refuse the insert without touching the table
              done         <= 1'b1;
              status       <= STATUS_FULL;
              region_bytes <= '0;
              slot         <= '0;
              fsm          <= S_IDLE;
            end else begin
              rd_slot    <= home;
              data_valid <= 1'b0;
              visits     <= '0;
              fsm        <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          // Advance the read pointer every cycle; evaluate the previous slot
          rd_slot    <= rd_slot_next;
          eval_slot  <= rd_slot;
          data_valid <= 1'b1;
          if (eval) begin
            priority if (ins_hit) begin
              live_count   <= live_count + LC_W'(1);
              done         <= 1'b1;
              status       <= STATUS_OK;
              region_bytes <= bytes_reg;
              slot         <= slot_ext[SLOT_OUT_W-1:0];
              fsm          <= S_IDLE;
            end else if (rem_hit) begin
              live_count   <= live_count - LC_W'(1);
              done         <= 1'b1;
              status       <= STATUS_OK;
              region_bytes <= rd_bytes;
              slot         <= slot_ext[SLOT_OUT_W-1:0];
              fsm          <= S_IDLE;
            end else if (rem_miss || lap_end) begin
              // Empty slot ends a remove; a full lap ends either operation
              done         <= 1'b1;
              status       <= (op_reg == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
              region_bytes <= '0;
              slot         <= '0;
              fsm          <= S_IDLE;
            end else begin
              visits <= visits + CNT_W'(1);
            end
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Occupancy never passes one half of the table
  assert property (@(posedge clk) disable iff (rst) live_count <= HALF_FULL)
    else $error("live_count above half of the table");

  // A failed result carries zero size and slot
  assert property (@(posedge clk) disable iff (rst)
    done && status != STATUS_OK |-> region_bytes == '0 && slot == '0)
    else $error("failed result with nonzero payload");

  // Results are single pulses: one item cannot finish in back-to-back cycles
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // Slot memories are written only by the clearing pass or a finishing probe
  assert property (@(posedge clk) disable iff (rst)
    st_we |-> fsm == S_CLEAR || eval)
    else $error("state memory written outside clear or probe");

  // An accepted transfer always makes the block busy next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after transfer");
`endif

endmodule

`default_nettype wire

FILE: tb/allocation_hash_table_checker.sv
`timescale 1ns / 1ps

module allocation_hash_table_checker
  import aht_pkg::*;
#(
  parameter int TABLE_SLOTS  = 1024,
  parameter int ADDRESS_BITS = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic                    operation,
  input  wire logic [ADDRESS_BITS-1:0] address,
  input  wire logic [REQ_W-1:0]        request_bytes,
  input  wire logic                    cfg_we,
  input  wire logic [PSHIFT_W-1:0]     cfg_wdata,
  input  wire logic                    done,
  input  wire logic [1:0]              status,
  input  wire logic [BYTES_W-1:0]      region_bytes,
  input  wire logic [SLOT_OUT_W-1:0]   slot,
  output int                           failures,
  output int                           outstanding
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]            code;
    logic [BYTES_W-1:0]    bytes;
    logic [SLOT_OUT_W-1:0] index;
  } region_result_t;

  // Shadow copy of the allocation table
  logic [1:0]              slot_kind [TABLE_SLOTS];
  logic [ADDRESS_BITS-1:0] slot_key  [TABLE_SLOTS];
  logic [BYTES_W-1:0]      slot_size [TABLE_SLOTS];
  int unsigned             live_entries;
  logic [PSHIFT_W-1:0]     page_shift_q;

  region_result_t pending_results[$];

  function automatic int unsigned home_of(logic [ADDRESS_BITS-1:0] key);
    return 32'((64'(key) >> HOME_SHIFT) % TABLE_SLOTS);
  endfunction

  function automatic int unsigned wrap_next(int unsigned s);
    return (s + 1 == TABLE_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic region_result_t insert_region(logic [ADDRESS_BITS-1:0] key,
                                                   logic [REQ_W-1:0] req);
    logic [63:0] page_mask;
    logic [63:0] rounded;
    int unsigned s;
    page_mask = (64'd1 << page_shift_q) - 64'd1;
    rounded   = (64'(req) + page_mask) & ~page_mask;
    if (live_entries >= TABLE_SLOTS / 2) return '{STATUS_FULL, '0, '0};
    s = home_of(key);
    repeat (TABLE_SLOTS) begin
      if (slot_kind[s] != SLOT_LIVE) begin
        slot_kind[s] = SLOT_LIVE;
        slot_key[s]  = key;
        slot_size[s] = rounded[BYTES_W-1:0];
        live_entries++;
        return '{STATUS_OK, rounded[BYTES_W-1:0], s[SLOT_OUT_W-1:0]};
      end
      s = wrap_next(s);
    end
    return '{STATUS_FULL, '0, '0};
  endfunction

  function automatic region_result_t remove_region(logic [ADDRESS_BITS-1:0] key);
    int unsigned s;
    s = home_of(key);
    repeat (TABLE_SLOTS) begin
      if (slot_kind[s] == SLOT_EMPTY) break;
      if (slot_kind[s] == SLOT_LIVE && slot_key[s] == key) begin
        slot_kind[s] = SLOT_TOMB;
        live_entries--;
        return '{STATUS_OK, slot_size[s], s[SLOT_OUT_W-1:0]};
      end
      s = wrap_next(s);
    end
    return '{STATUS_NOT_FOUND, '0, '0};
  endfunction

  always @(posedge clk) begin : watch
    region_result_t want;
    region_result_t predicted;
    if (rst) begin
      foreach (slot_kind[i]) slot_kind[i] = SLOT_EMPTY;
      live_entries = 0;
      page_shift_q = PAGE_SHIFT_RESET;
      pending_results.delete();
      failures = 0;
    end else begin
      // Score results before taking the new transfer of this edge
      if (done !== 1'b0) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("unexpected result: status=%0d bytes=%0h slot=%0d",
                     status, region_bytes, slot);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.code || region_bytes !== want.bytes || slot !== want.index) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("mismatch: expected status=%0d bytes=%0h slot=%0d, got status=%0d bytes=%0h slot=%0d",
                       want.code, want.bytes, want.index, status, region_bytes, slot);
          end
        end
      end
      if (cfg_we) page_shift_q = cfg_wdata;
      if (start && !busy) begin
        if (operation == OP_INSERT)
          predicted = insert_region(address, request_bytes);
        else
          predicted = remove_region(address);
        pending_results.insert(pending_results.size(), predicted);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/allocation_hash_table_core_test.sv
`timescale 1ns / 1ps

module allocation_hash_table_core_test
  import aht_pkg::*;
;

  localparam int SLOTS       = 1024;
  localparam int ADDR_W      = 48;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int HALF        = SLOTS / 2;
  localparam int NOISE_PCT   = 5;
  localparam int TAIL_CYCLES = 64;
  // Worst case: ~1800 transfers, each a full lap of probes plus the longest
  // sender gap, on top of the clearing pass after reset; taken several times over.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  // Fixed keys for the directed part
  localparam logic [ADDR_W-1:0] ADDR_ZERO      = '0;
  localparam logic [ADDR_W-1:0] ADDR_TOP       = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_TOP_PAGE  = 48'hFFFF_FFFF_F000;
  localparam logic [ADDR_W-1:0] ADDR_ABSENT    = 48'h5555_5555_5555;
  localparam logic [ADDR_W-1:0] ADDR_ALT       = 48'hAAAA_AAAA_A000;
  localparam logic [ADDR_W-1:0] ADDR_MID       = 48'h0123_4567_89AB;
  localparam logic [ADDR_W-1:0] ADDR_HIGH_BIT  = 48'h8000_0000_0000;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] key;
    logic [REQ_W-1:0]  req;
  } region_request_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  operation;
  logic [ADDR_W-1:0]     address;
  logic [REQ_W-1:0]      request_bytes;
  logic                  cfg_we;
  logic [PSHIFT_W-1:0]   cfg_wdata;
  logic                  done;
  logic [1:0]            status;
  logic [BYTES_W-1:0]    region_bytes;
  logic [SLOT_OUT_W-1:0] slot;
  int                    failures;
  int                    outstanding;
  int unsigned           cycle_count = 0;

  // Requests still to be sent, and the keys the table should hold
  region_request_t   stock[$];
  logic [ADDR_W-1:0] live_pool[$];
  logic [ADDR_W-1:0] freed_pool[$];

  allocation_hash_table_core #(
    .TABLE_SLOTS (SLOTS),
    .ADDRESS_BITS(ADDR_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .address      (address),
    .request_bytes(request_bytes),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .region_bytes (region_bytes),
    .slot         (slot)
  );

  allocation_hash_table_checker #(
    .TABLE_SLOTS (SLOTS),
    .ADDRESS_BITS(ADDR_W)
  ) checker_inst (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .address      (address),
    .request_bytes(request_bytes),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .region_bytes (region_bytes),
    .slot         (slot),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Random key whose home slot is forced; upper and page-offset bits stay random
  function automatic logic [ADDR_W-1:0] addr_at_home(int unsigned home);
    logic [63:0] r;
    r = {$urandom, $urandom};
    r[HOME_SHIFT +: SLOT_BITS] = home[SLOT_BITS-1:0];
    return r[ADDR_W-1:0];
  endfunction

  // Mix of byte counts: full range, small, both extremes, and varied magnitudes
  function automatic logic [REQ_W-1:0] random_request();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 20000);
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic void add_request(logic op, logic [ADDR_W-1:0] key,
                                      logic [REQ_W-1:0] req);
    region_request_t item;
    item = '{op, key, req};
    stock.insert(stock.size(), item);
  endfunction

  // Insert one fresh key at each home of [base, base+HALF) in shuffled order,
  // with stray removes of absent keys mixed in.
  function automatic void fill_homes(int unsigned base);
    int unsigned order[$];
    int unsigned pick;
    logic [ADDR_W-1:0] key;
    for (int i = 0; i < HALF; i++) order.insert(order.size(), base + i);
    while (order.size() > 0) begin
      if ($urandom_range(0, 99) < NOISE_PCT)
        add_request(OP_REMOVE, addr_at_home($urandom_range(0, SLOTS - 1)), $urandom);
      pick = $urandom_range(0, order.size() - 1);
      key  = addr_at_home(order[pick]);
      order.delete(pick);
      add_request(OP_INSERT, key, random_request());
      live_pool.insert(live_pool.size(), key);
    end
  endfunction

  // Send count requests from the stock; hold start high across back-to-back
  // transfers, then wait for every result before returning.
  task automatic send_requests(int idle_pct, int count);
    region_request_t item;
    repeat (count) begin
      item = stock.pop_front();
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      start         <= 1'b1;
      operation     <= item.op;
      address       <= item.key;
      request_bytes <= item.req;
      // A transfer happens at the first edge that sees busy low
      do @(posedge clk); while (busy);
    end
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_page_shift(logic [PSHIFT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    int unsigned roll;
    int total;
    logic [ADDR_W-1:0] key;

    rst           = 1'b1;
    start         = 1'b0;
    operation     = OP_INSERT;
    address       = '0;
    request_bytes = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset page size: zero request, duplicate keys, removal past a tombstone,
    // then a miss that stops at an empty slot.
    add_request(OP_INSERT, ADDR_ZERO, 32'd0);
    add_request(OP_INSERT, ADDR_ZERO, 32'd1);
    add_request(OP_REMOVE, ADDR_ZERO, $urandom);
    add_request(OP_REMOVE, ADDR_ZERO, $urandom);
    add_request(OP_REMOVE, ADDR_ZERO, $urandom);
    // Top of the key range: largest request rounds to 2^32; the second key
    // shares the last home slot, so it wraps onto the tombstone at slot 0.
    add_request(OP_INSERT, ADDR_TOP, '1);
    add_request(OP_INSERT, ADDR_TOP_PAGE, 32'd4096);
    add_request(OP_REMOVE, ADDR_TOP_PAGE, $urandom);
    add_request(OP_REMOVE, ADDR_TOP, $urandom);
    add_request(OP_REMOVE, ADDR_ABSENT, '1);
    send_requests(33, stock.size());

    // Widest page setting, all register bits high
    write_page_shift(5'd31);
    add_request(OP_INSERT, ADDR_ALT, 32'd1);
    add_request(OP_INSERT, ADDR_ALT, '1);
    add_request(OP_INSERT, ADDR_ALT, 32'd0);
    send_requests(33, stock.size());

    // Byte-granular pages: sizes pass through unrounded
    write_page_shift(5'd0);
    add_request(OP_INSERT, ADDR_MID, '1);
    add_request(OP_INSERT, ADDR_MID, 32'd12345);
    send_requests(33, stock.size());

    // Top of the nominal range, then drop every directed entry
    write_page_shift(5'd16);
    add_request(OP_INSERT, ADDR_HIGH_BIT, 32'd1);
    add_request(OP_REMOVE, ADDR_ALT, $urandom);
    add_request(OP_REMOVE, ADDR_ALT, $urandom);
    add_request(OP_REMOVE, ADDR_ALT, $urandom);
    add_request(OP_REMOVE, ADDR_MID, $urandom);
    add_request(OP_REMOVE, ADDR_MID, $urandom);
    add_request(OP_REMOVE, ADDR_HIGH_BIT, $urandom);
    send_requests(33, stock.size());

    // Random part. Fill the lower half of the homes up to the occupancy limit,
    // and push a few inserts past it.
    fill_homes(0);
    repeat (3) add_request(OP_INSERT, addr_at_home($urandom_range(0, SLOTS - 1)),
                           random_request());

    // Drain in random order; stray removes of keys already gone must miss
    while (live_pool.size() > 0) begin
      if ($urandom_range(0, 99) < NOISE_PCT && freed_pool.size() > 0)
        add_request(OP_REMOVE, freed_pool[$urandom_range(0, freed_pool.size() - 1)],
                    $urandom);
      pick = $urandom_range(0, live_pool.size() - 1);
      add_request(OP_REMOVE, live_pool[pick], $urandom);
      freed_pool.insert(freed_pool.size(), live_pool[pick]);
      live_pool.delete(pick);
    end

    // Fill the upper half: now every slot is live or a tombstone, so a miss
    // has to walk one full lap, and one more insert is refused.
    fill_homes(HALF);
    add_request(OP_REMOVE, addr_at_home($urandom_range(0, SLOTS - 1)), $urandom);
    add_request(OP_INSERT, addr_at_home($urandom_range(0, SLOTS - 1)), random_request());

    // Churn at the occupancy limit: hits, fresh inserts that reuse tombstones
    // or get refused, duplicates, and rare full-lap misses.
    repeat (100) begin
      roll = $urandom_range(0, 99);
      if (roll < 45 && live_pool.size() > 0) begin
        pick = $urandom_range(0, live_pool.size() - 1);
        add_request(OP_REMOVE, live_pool[pick], $urandom);
        live_pool.delete(pick);
      end else if (roll < 85) begin
        key = addr_at_home($urandom_range(0, SLOTS - 1));
        add_request(OP_INSERT, key, random_request());
        live_pool.insert(live_pool.size(), key);
      end else if (roll < 95 && live_pool.size() > 0) begin
        key = live_pool[$urandom_range(0, live_pool.size() - 1)];
        add_request(OP_INSERT, key, random_request());
        live_pool.insert(live_pool.size(), key);
      end else begin
        add_request(OP_REMOVE, addr_at_home($urandom_range(0, SLOTS - 1)), $urandom);
      end
    end

    // Three idling phases, each with its own page size; the table carries over
    total = stock.size();
    write_page_shift(5'd12);
    send_requests(33, total / 3);
    write_page_shift(5'd21);
    send_requests(85, total / 3);
    write_page_shift(5'd3);
    send_requests(0, stock.size());

    // Hold a little longer to catch any stray result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/aht_pkg.sv
rtl/aht_ram.sv
rtl/aht_home.sv
rtl/allocation_hash_table_core.sv
tb/allocation_hash_table_checker.sv
tb/allocation_hash_table_core_test.sv
